@@ hdl/sensor_code_matcher_repeat_count_defines.svh @@
// Assertion macros for the code matcher.
// Needs clk and rst_n in the scope of use.
`ifndef SENSOR_CODE_MATCHER_REPEAT_COUNT_DEFINES_SVH
`define SENSOR_CODE_MATCHER_REPEAT_COUNT_DEFINES_SVH

// same-cycle implication
`define SCMRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/scmrc_pkg.sv @@
// Shared types and constants of the code matcher.
// No dependencies.
package scmrc_pkg;

  localparam int WORD_W        = 64;
  localparam int CODE_W        = 56;
  localparam int INDEX_W       = 9;
  localparam int COUNT_FIELD_W = 16;
  localparam int EC_W          = 10;

  localparam logic [WORD_W-1:0] TOP_BYTE_OFFSET = 64'hFF00_0000_0000_0000;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CODE = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_NEW     = 1'b1;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] entry_index;
    logic [CODE_W-1:0]  entry_code;
    logic               entry_publish;
    logic [WORD_W-1:0]  code_word;
  } in_word_t;

  typedef struct packed {
    logic                     report_kind;
    logic                     known;
    logic [INDEX_W-1:0]       table_index;
    logic [WORD_W-1:0]        raw_code;
    logic [COUNT_FIELD_W-1:0] times_seen;
    logic                     publish;
    logic                     last;
  } out_word_t;

endpackage

@@ hdl/scmrc_in_if.sv @@
// Input channel of the code matcher: valid/ready and one input word.
// Depends on scmrc_pkg.
interface scmrc_in_if;
  logic                 valid;
  logic                 ready;
  scmrc_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/scmrc_out_if.sv @@
// Result channel of the code matcher: valid/ready and one result word.
// Depends on scmrc_pkg.
interface scmrc_out_if;
  logic                 valid;
  logic                 ready;
  scmrc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sensor_code_matcher_repeat_count.sv @@
// Load words and repeated code words: taken in the idle state, no result.
// New code word: linear search at one read per cycle of the single-port code table
// over the first min(entry_count, TABLE_DEPTH) entries, ending sooner on a match;
// the next word is accepted once the last result is loaded.
// Synchronous active-low reset clears control and history; the table is not cleared.
// Depends on scmrc_pkg, scmrc_in_if, scmrc_out_if and the defines header.
`include "sensor_code_matcher_repeat_count_defines.svh"

module sensor_code_matcher_repeat_count #(
  parameter int TABLE_DEPTH = 512,
  parameter int COUNT_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [scmrc_pkg::EC_W-1:0]   cfg_wdata,
  scmrc_in_if.sink                     in_ch,
  scmrc_out_if.source                  out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LIM_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (LIM_W > scmrc_pkg::EC_W) ? LIM_W : scmrc_pkg::EC_W;
  localparam int IXO_W = (IDX_W > scmrc_pkg::INDEX_W) ? IDX_W : scmrc_pkg::INDEX_W;
  localparam int CNO_W = (COUNT_BITS > scmrc_pkg::COUNT_FIELD_W) ?
                         COUNT_BITS : scmrc_pkg::COUNT_FIELD_W;
  localparam int MEM_W = scmrc_pkg::CODE_W + 1;
  localparam logic [CMP_W-1:0]      DEPTH_C = CMP_W'(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SUM    = 4'b0100,
    S_NEW    = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [scmrc_pkg::EC_W-1:0]       ec_r, ec_nxt;
  logic [scmrc_pkg::WORD_W-1:0]     prev_word_r, prev_word_nxt;
  logic [IDX_W-1:0]                 prev_idx_r, prev_idx_nxt;
  logic                             prev_unk_r, prev_unk_nxt;
  logic [COUNT_BITS-1:0]            rep_cnt_r, rep_cnt_nxt;
  logic [scmrc_pkg::WORD_W-1:0]     word_r, word_nxt;
  logic                             tgt_ok_r, tgt_ok_nxt;
  logic [scmrc_pkg::CODE_W-1:0]     tgt_code_r, tgt_code_nxt;
  logic [LIM_W-1:0]                 limit_r, limit_nxt;
  logic [LIM_W-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]                 cmp_idx_r, cmp_idx_nxt;
  logic                             hit_r, hit_nxt;
  logic [IDX_W-1:0]                 found_r, found_nxt;
  logic                             pub_r, pub_nxt;
  logic                             out_valid_r, out_valid_nxt;
  scmrc_pkg::out_word_t             out_data_r, out_data_nxt;

  logic [MEM_W-1:0]                 mem [TABLE_DEPTH];
  logic [MEM_W-1:0]                 mem_rd_r;

  logic                             in_acc;
  logic                             out_free;
  logic [CMP_W-1:0]                 ec_ext;
  logic [CMP_W-1:0]                 lim_full;
  logic [CMP_W-1:0]                 ei_ext;
  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             mem_hit;
  logic [scmrc_pkg::WORD_W-1:0]     target;
  logic [IXO_W-1:0]                 prev_idx_ext;
  logic [IXO_W-1:0]                 found_ext;
  logic [CNO_W-1:0]                 cnt_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign ec_ext   = CMP_W'(ec_r);
  assign lim_full = (ec_ext > DEPTH_C) ? DEPTH_C : ec_ext;
  assign ei_ext   = CMP_W'(in_ch.data.entry_index);
  assign wr_en    = in_acc && (in_ch.data.action == scmrc_pkg::ACT_LOAD) && (ei_ext < DEPTH_C);
  assign wr_addr  = ei_ext[IDX_W-1:0];
  assign target   = in_ch.data.code_word - scmrc_pkg::TOP_BYTE_OFFSET;

  assign mem_hit  = rd_vld_r && tgt_ok_r && (mem_rd_r[scmrc_pkg::CODE_W-1:0] == tgt_code_r);
  assign rd_en    = (state_r == S_SEARCH) && (rd_ptr_r < limit_r) && !mem_hit;
  assign rd_addr  = rd_ptr_r[IDX_W-1:0];

  assign prev_idx_ext = IXO_W'(prev_idx_r);
  assign found_ext    = IXO_W'(found_r);
  assign cnt_ext      = CNO_W'(rep_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    ec_nxt        = cfg_we ? cfg_wdata : ec_r;
    prev_word_nxt = prev_word_r;
    prev_idx_nxt  = prev_idx_r;
    prev_unk_nxt  = prev_unk_r;
    rep_cnt_nxt   = rep_cnt_r;
    word_nxt      = word_r;
    tgt_ok_nxt    = tgt_ok_r;
    tgt_code_nxt  = tgt_code_r;
    limit_nxt     = limit_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_vld_nxt    = rd_en;
    cmp_idx_nxt   = rd_en ? rd_addr : cmp_idx_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    pub_nxt       = pub_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.data.action == scmrc_pkg::ACT_CODE)) begin
          if (in_ch.data.code_word == prev_word_r) begin
            if (rep_cnt_r != CNT_MAX) begin
              rep_cnt_nxt = rep_cnt_r + COUNT_BITS'(1);
            end
          end else begin
            word_nxt     = in_ch.data.code_word;
            tgt_ok_nxt   = (target[scmrc_pkg::WORD_W-1:scmrc_pkg::CODE_W] == '0);
            tgt_code_nxt = target[scmrc_pkg::CODE_W-1:0];
            limit_nxt    = lim_full[LIM_W-1:0];
            rd_ptr_nxt   = '0;
            hit_nxt      = 1'b0;
            found_nxt    = '0;
            pub_nxt      = 1'b0;
            state_nxt    = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (rd_en) begin
          rd_ptr_nxt = rd_ptr_r + LIM_W'(1);
        end
        if (mem_hit) begin
          hit_nxt   = 1'b1;
          found_nxt = cmp_idx_r;
          pub_nxt   = mem_rd_r[scmrc_pkg::CODE_W];
          state_nxt = (rep_cnt_r != '0) ? S_SUM : S_NEW;
        end else if (!rd_vld_r && (rd_ptr_r >= limit_r)) begin
          state_nxt = (rep_cnt_r != '0) ? S_SUM : S_NEW;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.report_kind = scmrc_pkg::KIND_SUMMARY;
          out_data_nxt.known       = !prev_unk_r;
          out_data_nxt.table_index = prev_idx_ext[scmrc_pkg::INDEX_W-1:0];
          out_data_nxt.raw_code    = prev_word_r;
          out_data_nxt.times_seen  = cnt_ext[scmrc_pkg::COUNT_FIELD_W-1:0];
          out_data_nxt.publish     = 1'b0;
          out_data_nxt.last        = 1'b0;
          state_nxt                = S_NEW;
        end
      end
      S_NEW: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.report_kind = scmrc_pkg::KIND_NEW;
          out_data_nxt.known       = hit_r;
          out_data_nxt.table_index = found_ext[scmrc_pkg::INDEX_W-1:0];
          out_data_nxt.raw_code    = word_r;
          out_data_nxt.times_seen  = scmrc_pkg::COUNT_FIELD_W'(1);
          out_data_nxt.publish     = pub_r;
          out_data_nxt.last        = 1'b1;
          prev_word_nxt            = word_r;
          prev_idx_nxt             = found_r;
          prev_unk_nxt             = !hit_r;
          rep_cnt_nxt              = COUNT_BITS'(1);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ec_r        <= '0;
      prev_word_r <= '0;
      prev_idx_r  <= '0;
      prev_unk_r  <= 1'b0;
      rep_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ec_r        <= ec_nxt;
      prev_word_r <= prev_word_nxt;
      prev_idx_r  <= prev_idx_nxt;
      prev_unk_r  <= prev_unk_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    tgt_ok_r   <= tgt_ok_nxt;
    tgt_code_r <= tgt_code_nxt;
    limit_r    <= limit_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    pub_r      <= pub_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_ch.data.entry_publish, in_ch.data.entry_code};
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  `SCMRC_ASSERT_NOW(a_summary_waits_in_new, out_valid_r && !out_data_r.last, state_r == S_NEW, "summary pending outside new-report state")
  `SCMRC_ASSERT_NOW(a_hit_within_limit, (state_r == S_SUM || state_r == S_NEW) && hit_r, found_r < limit_r, "match index beyond searched range")
  `SCMRC_ASSERT_NOW(a_new_report_is_history, out_valid_r && out_data_r.report_kind == scmrc_pkg::KIND_NEW, out_data_r.raw_code == prev_word_r, "new report differs from held previous word")

endmodule
